// ----- hdl/ternary_tryte_alu_core_macros.svh -----
// assertion helpers for the tryte alu
`ifndef TERNARY_TRYTE_ALU_CORE_MACROS_SVH
`define TERNARY_TRYTE_ALU_CORE_MACROS_SVH
`define TTA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/tta_pkg.sv -----
package tta_pkg;
  localparam int TRITS = 6;
  localparam int FW = 2 * TRITS;
  localparam int RW = FW + 2;
  localparam int CW = 4;
  localparam int CNTW = $clog2(TRITS);
  localparam int AW = $clog2(TRITS + 1);
  localparam int VW = AW + 2;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_ROTL = 4'd4, CMD_ROTR = 4'd5, CMD_ROTLC = 4'd6, CMD_ROTRC = 4'd7,
    CMD_AND = 4'd8, CMD_OR = 4'd9, CMD_XOR = 4'd10, CMD_CMP = 4'd11
  } cmd_t;

  typedef logic [1:0] trit_t;
  typedef logic [TRITS-1:0][1:0] tryte_t;
  typedef logic [TRITS:0][1:0] ext_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_RUN = 4'b0010, ST_FIN = 4'b0100, ST_OUT = 4'b1000
  } state_t;

  function automatic trit_t fix_trit(input logic [1:0] t);
    fix_trit = (t == 2'd3) ? 2'd2 : t;
  endfunction

  // digit sum 0..8 split into {carry, digit}
  function automatic logic [3:0] tsum(input logic [3:0] s);
    if (s >= 4'd6) tsum = {2'd2, 2'(s - 4'd6)};
    else if (s >= 4'd3) tsum = {2'd1, 2'(s - 4'd3)};
    else tsum = {2'd0, s[1:0]};
  endfunction

  function automatic trit_t zero_code(input logic z);
    zero_code = z ? 2'd2 : 2'd0;
  endfunction

  // 1 - (a-1)(b-1)
  function automatic trit_t xor_trit(input trit_t a, input trit_t b);
    if (a == 2'd1 || b == 2'd1) xor_trit = 2'd1;
    else if (a == b) xor_trit = 2'd0;
    else xor_trit = 2'd2;
  endfunction
endpackage

// ----- hdl/tta_serial.sv -----
// trit-serial datapath: add/sub, shift-add mul, restoring div, rotate amounts
module tta_serial import tta_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  cmd_t          cmd,
  input  tryte_t        a,
  input  tryte_t        b,
  output logic          done,
  output tryte_t        lo,
  output tryte_t        hi,
  output trit_t         cout,
  output logic [AW-1:0] amt_rot,
  output logic [AW-1:0] amt_ring
);
  cmd_t op_r, op_nxt;
  tryte_t x_r, x_nxt, y_r, y_nxt, lo_r, lo_nxt, acc_r, acc_nxt;
  ext_t d2_r, d2_nxt;
  trit_t c_r, c_nxt;
  logic [AW-1:0] ar_r, ar_nxt, ag_r, ag_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [3:0] ts;
  trit_t cy, yt;
  ext_t sum, t1, t2, r3, yb;
  logic ge1, ge2;
  logic [VW-1:0] vr, vg;

  assign done = busy_r && (cnt_r == CNTW'(TRITS - 1));
  assign lo = lo_r;
  assign hi = acc_r;
  assign cout = c_r;
  assign amt_rot = ar_r;
  assign amt_ring = ag_r;

  always_comb begin
    op_nxt = op_r; x_nxt = x_r; y_nxt = y_r; lo_nxt = lo_r; acc_nxt = acc_r;
    d2_nxt = d2_r; c_nxt = c_r; ar_nxt = ar_r; ag_nxt = ag_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    ts = '0; cy = '0; yt = '0; sum = '0; t1 = '0; t2 = '0; r3 = '0; yb = '0;
    ge1 = 1'b0; ge2 = 1'b0; vr = '0; vg = '0;
    if (start) begin
      busy_nxt = 1'b1; cnt_nxt = '0; op_nxt = cmd;
      x_nxt = a; y_nxt = b; lo_nxt = '0; acc_nxt = '0; ar_nxt = '0; ag_nxt = '0;
      c_nxt = (cmd == CMD_SUB) ? 2'd1 : 2'd0;
      // twice the divisor for the second quotient digit
      for (int i = 0; i < TRITS; i++) begin
        ts = tsum(4'(b[i]) + 4'(b[i]) + 4'(cy));
        d2_nxt[i] = ts[1:0];
        cy = ts[3:2];
      end
      d2_nxt[TRITS] = cy;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(TRITS - 1)) busy_nxt = 1'b0;
      case (op_r)
        CMD_ADD, CMD_SUB: begin
          yt = (op_r == CMD_SUB) ? 2'd2 - y_r[0] : y_r[0];
          ts = tsum(4'(x_r[0]) + 4'(yt) + 4'(c_r));
          c_nxt = ts[3:2];
          lo_nxt = {ts[1:0], lo_r[TRITS-1:1]};
          x_nxt = {2'd0, x_r[TRITS-1:1]};
          y_nxt = {2'd0, y_r[TRITS-1:1]};
        end
        CMD_MUL: begin
          // acc += a * b digit, lsb digit of b first, low trit shifts out
          for (int i = 0; i < TRITS; i++) begin
            ts = tsum(4'(acc_r[i]) + ((y_r[0] != 2'd0) ? 4'(x_r[i]) : 4'd0)
                      + ((y_r[0] == 2'd2) ? 4'(x_r[i]) : 4'd0) + 4'(cy));
            sum[i] = ts[1:0];
            cy = ts[3:2];
          end
          sum[TRITS] = cy;
          lo_nxt = {sum[0], lo_r[TRITS-1:1]};
          acc_nxt = sum[TRITS:1];
          y_nxt = {2'd0, y_r[TRITS-1:1]};
        end
        CMD_DIV: begin
          // partial remainder times 3 plus next dividend trit, msb first
          r3 = {acc_r, x_r[TRITS-1]};
          yb = {2'd0, y_r};
          cy = 2'd1;
          for (int i = 0; i <= TRITS; i++) begin
            ts = tsum(4'(r3[i]) + 4'(2'd2 - yb[i]) + 4'(cy));
            t1[i] = ts[1:0];
            cy = ts[3:2];
          end
          ge1 = cy[0];
          cy = 2'd1;
          for (int i = 0; i <= TRITS; i++) begin
            ts = tsum(4'(r3[i]) + 4'(2'd2 - d2_r[i]) + 4'(cy));
            t2[i] = ts[1:0];
            cy = ts[3:2];
          end
          ge2 = cy[0];
          acc_nxt = ge2 ? t2[TRITS-1:0] : ge1 ? t1[TRITS-1:0] : r3[TRITS-1:0];
          lo_nxt = {lo_r[TRITS-2:0], ge2 ? 2'd2 : ge1 ? 2'd1 : 2'd0};
          x_nxt = {x_r[TRITS-2:0], 2'd0};
        end
        CMD_ROTL, CMD_ROTR, CMD_ROTLC, CMD_ROTRC: begin
          // amount modulo TRITS and TRITS+1, msb trit first
          vr = VW'({ar_r, 1'b0}) + VW'(ar_r) + VW'(y_r[TRITS-1]);
          if (vr >= VW'(2 * TRITS)) vr = vr - VW'(2 * TRITS);
          else if (vr >= VW'(TRITS)) vr = vr - VW'(TRITS);
          vg = VW'({ag_r, 1'b0}) + VW'(ag_r) + VW'(y_r[TRITS-1]);
          if (vg >= VW'(2 * (TRITS + 1))) vg = vg - VW'(2 * (TRITS + 1));
          else if (vg >= VW'(TRITS + 1)) vg = vg - VW'(TRITS + 1);
          ar_nxt = AW'(vr);
          ag_nxt = AW'(vg);
          y_nxt = {y_r[TRITS-2:0], 2'd0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; x_r <= x_nxt; y_r <= y_nxt; lo_r <= lo_nxt; acc_r <= acc_nxt;
    d2_r <= d2_nxt; c_r <= c_nxt; ar_r <= ar_nxt; ag_r <= ag_nxt;
  end
endmodule

// ----- hdl/ternary_tryte_alu_core.sv -----
// the input beat is taken in ST_IDLE; the trit-serial steps run in ST_RUN, the result
// is registered in ST_FIN and offered in ST_OUT, the same path for every command
// one item in flight, in_stall high until the result leaves; out_stall holds ST_OUT
// reset: rst_n synchronous, clears the status trits and the controller
module ternary_tryte_alu_core import tta_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [CW-1:0] in_command,
  input  logic [FW-1:0] in_operand_a,
  input  logic [FW-1:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [FW-1:0] out_result_low,
  output logic [FW-1:0] out_result_high,
  output logic [1:0]  out_zero_trit,
  output logic [1:0]  out_carry_trit,
  output logic        out_divide_by_zero
);
  state_t st_r;
  tryte_t a_r, b_r, r_r, h_r, r_nxt, h_nxt, a_fix, b_fix;
  cmd_t cmd_r;
  trit_t cs_r, zs_r, cs_nxt, zs_nxt;
  logic dbz_r, dbz_nxt;
  logic ser_start, ser_done;
  tryte_t ser_lo, ser_hi;
  trit_t ser_cout;
  logic [AW-1:0] amt_rot, amt_ring;
  logic [2*FW-1:0] rot_l, rot_r;
  logic [2*RW-1:0] ring_l, ring_r;
  tryte_t rot_res, lg_res;
  logic [RW-1:0] ring_res;

  assign in_stall = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_result_low = FW'(r_r);
  assign out_result_high = FW'(h_r);
  assign out_zero_trit = zs_r;
  assign out_carry_trit = cs_r;
  assign out_divide_by_zero = dbz_r;

  assign ser_start = (st_r == ST_IDLE) && in_valid;

  always_comb begin
    for (int i = 0; i < TRITS; i++) begin
      a_fix[i] = fix_trit(in_operand_a[2*i +: 2]);
      b_fix[i] = fix_trit(in_operand_b[2*i +: 2]);
    end
  end

  tta_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ser_start),
    .cmd      (cmd_t'(in_command)),
    .a        (a_fix),
    .b        (b_fix),
    .done     (ser_done),
    .lo       (ser_lo),
    .hi       (ser_hi),
    .cout     (ser_cout),
    .amt_rot  (amt_rot),
    .amt_ring (amt_ring)
  );

  // rotates on a doubled copy; the ring puts the carry trit above the msb
  assign rot_l = {a_r, a_r} << {amt_rot, 1'b0};
  assign rot_r = {a_r, a_r} >> {amt_rot, 1'b0};
  assign rot_res = (cmd_r == CMD_ROTL) ? rot_l[2*FW-1:FW] : rot_r[FW-1:0];
  assign ring_l = {cs_r, a_r, cs_r, a_r} << {amt_ring, 1'b0};
  assign ring_r = {cs_r, a_r, cs_r, a_r} >> {amt_ring, 1'b0};
  assign ring_res = (cmd_r == CMD_ROTLC) ? ring_l[2*RW-1:RW] : ring_r[RW-1:0];

  always_comb begin
    for (int i = 0; i < TRITS; i++) begin
      case (cmd_r)
        CMD_AND: lg_res[i] = (a_r[i] < b_r[i]) ? a_r[i] : b_r[i];
        CMD_OR:  lg_res[i] = (a_r[i] > b_r[i]) ? a_r[i] : b_r[i];
        CMD_XOR: lg_res[i] = xor_trit(a_r[i], b_r[i]);
        default: lg_res[i] = 2'd2 - a_r[i];
      endcase
    end
  end

  always_comb begin
    r_nxt = '0; h_nxt = '0; dbz_nxt = 1'b0; cs_nxt = cs_r; zs_nxt = zs_r;
    case (cmd_r)
      CMD_ADD: begin
        r_nxt = ser_lo; cs_nxt = ser_cout; zs_nxt = zero_code(ser_lo == '0);
      end
      CMD_SUB: begin
        r_nxt = ser_lo; cs_nxt = (ser_cout == 2'd1) ? 2'd2 : 2'd1;
        zs_nxt = zero_code(ser_lo == '0);
      end
      CMD_MUL: begin
        r_nxt = ser_lo; h_nxt = ser_hi; cs_nxt = 2'd0;
        zs_nxt = zero_code(ser_lo == '0 && ser_hi == '0);
      end
      CMD_DIV: begin
        if (b_r == '0) begin
          r_nxt = {TRITS{2'd2}}; h_nxt = a_r; dbz_nxt = 1'b1;
        end else begin
          r_nxt = ser_lo; h_nxt = ser_hi;
        end
        cs_nxt = 2'd0; zs_nxt = zero_code(a_r == '0);
      end
      CMD_ROTL, CMD_ROTR: begin
        r_nxt = rot_res; zs_nxt = zero_code(rot_res == '0);
      end
      CMD_ROTLC, CMD_ROTRC: begin
        // rotate by zero keeps both status trits
        if (amt_ring == '0) r_nxt = a_r;
        else begin
          r_nxt = ring_res[FW-1:0]; cs_nxt = ring_res[RW-1:FW];
          zs_nxt = zero_code(ring_res[FW-1:0] == '0);
        end
      end
      CMD_AND, CMD_OR, CMD_XOR, CMD_CMP: begin
        r_nxt = lg_res; zs_nxt = zero_code(lg_res == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cs_r <= '0; zs_r <= '0; dbz_r <= 1'b0;
    end else begin
      case (st_r)
        ST_IDLE: if (in_valid) begin
          a_r <= a_fix; b_r <= b_fix;
          cmd_r <= cmd_t'(in_command);
          st_r <= ST_RUN;
        end
        ST_RUN: if (ser_done) st_r <= ST_FIN;
        ST_FIN: begin
          r_r <= r_nxt; h_r <= h_nxt; dbz_r <= dbz_nxt;
          cs_r <= cs_nxt; zs_r <= zs_nxt;
          st_r <= ST_OUT;
        end
        ST_OUT: if (!out_stall) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/tta_checker.sv -----
module tta_checker import tta_pkg::*; (
  input logic clk, rst_n, in_stall, out_valid, out_stall,
  input logic [1:0] out_zero_trit, out_carry_trit,
  input logic out_divide_by_zero
);
  `include "ternary_tryte_alu_core_macros.svh"
  `TTA_ASSERT_IMPL(a_zero_code, out_valid, out_zero_trit != 2'd1 && out_zero_trit != 2'd3, "bad zero trit")
  `TTA_ASSERT_IMPL(a_carry_code, out_valid, out_carry_trit != 2'd3, "bad carry trit")
  `TTA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "result dropped")
  `TTA_ASSERT_IMPL(a_one, out_valid, in_stall, "accept while result pending")
  `TTA_ASSERT_IMPL(a_dbz_carry, out_valid && out_divide_by_zero, out_carry_trit == 2'd0, "bad div carry")
endmodule

bind ternary_tryte_alu_core tta_checker u_chk (.*);

// ----- test/ternary_tryte_alu_core_chk.sv -----
module ternary_tryte_alu_core_chk import tta_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [CW-1:0] in_command,
  input  logic [FW-1:0] in_operand_a,
  input  logic [FW-1:0] in_operand_b,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [FW-1:0] out_result_low,
  input  logic [FW-1:0] out_result_high,
  input  logic [1:0]    out_zero_trit,
  input  logic [1:0]    out_carry_trit,
  input  logic          out_divide_by_zero,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FW-1:0] lo;
    logic [FW-1:0] hi;
    logic [1:0]    zero;
    logic [1:0]    carry;
    logic          dbz;
  } alu_result_t;

  alu_result_t alu_results_q[$];
  logic [1:0] carry_st, zero_st;

  function automatic int tryte_value(logic [FW-1:0] p);
    int v;
    logic [1:0] t;
    v = 0;
    for (int i = TRITS - 1; i >= 0; i--) begin
      t = p[2*i +: 2];
      v = v * 3 + ((t == 2'd3) ? 2 : int'(t));
    end
    return v;
  endfunction

  function automatic logic [FW-1:0] tryte_pack(int v);
    logic [FW-1:0] p;
    p = '0;
    for (int i = 0; i < TRITS; i++) begin
      p[2*i +: 2] = 2'(v % 3);
      v = v / 3;
    end
    return p;
  endfunction

  function automatic logic [1:0] zero_of(int v);
    return (v == 0) ? 2'd2 : 2'd0;
  endfunction

  // updates carry_st/zero_st
  function automatic alu_result_t alu_compute(logic [3:0] cmd, logic [FW-1:0] pa,
                                              logic [FW-1:0] pb);
    alu_result_t res;
    int va, vb, m, s, amt;
    int ta[TRITS], tb[TRITS], tr[TRITS], ring[TRITS+1], nr[TRITS+1];
    res = '0;
    m = 1;
    for (int i = 0; i < TRITS; i++) begin
      m *= 3;
      ta[i] = (pa[2*i +: 2] == 2'd3) ? 2 : int'(pa[2*i +: 2]);
      tb[i] = (pb[2*i +: 2] == 2'd3) ? 2 : int'(pb[2*i +: 2]);
    end
    va = tryte_value(pa);
    vb = tryte_value(pb);
    case (cmd)
      CMD_ADD: begin
        s = va + vb;
        carry_st = (s >= m) ? 2'd1 : 2'd0;
        if (s >= m) s -= m;
        res.lo = tryte_pack(s);
        zero_st = zero_of(s);
      end
      CMD_SUB: begin
        s = (va >= vb) ? va - vb : va + m - vb;
        carry_st = (va >= vb) ? 2'd2 : 2'd1;
        res.lo = tryte_pack(s);
        zero_st = zero_of(s);
      end
      CMD_MUL: begin
        s = va * vb;
        res.lo = tryte_pack(s % m);
        res.hi = tryte_pack(s / m);
        carry_st = 2'd0;
        zero_st = zero_of(s);
      end
      CMD_DIV: begin
        if (vb == 0) begin
          res.lo = tryte_pack(m - 1);
          res.hi = tryte_pack(va);
          res.dbz = 1'b1;
        end else begin
          res.lo = tryte_pack(va / vb);
          res.hi = tryte_pack(va % vb);
        end
        carry_st = 2'd0;
        zero_st = zero_of(va);
      end
      CMD_ROTL, CMD_ROTR: begin
        amt = vb % TRITS;
        for (int i = 0; i < TRITS; i++)
          if (cmd == CMD_ROTL) tr[(i + amt) % TRITS] = ta[i];
          else tr[i] = ta[(i + amt) % TRITS];
        s = 0;
        for (int i = TRITS - 1; i >= 0; i--) s = s * 3 + tr[i];
        res.lo = tryte_pack(s);
        zero_st = zero_of(s);
      end
      CMD_ROTLC, CMD_ROTRC: begin
        amt = vb % (TRITS + 1);
        if (amt == 0) begin
          s = va;
        end else begin
          for (int i = 0; i < TRITS; i++) ring[i] = ta[i];
          ring[TRITS] = int'(carry_st);
          for (int i = 0; i <= TRITS; i++)
            if (cmd == CMD_ROTLC) nr[(i + amt) % (TRITS + 1)] = ring[i];
            else nr[i] = ring[(i + amt) % (TRITS + 1)];
          s = 0;
          for (int i = TRITS - 1; i >= 0; i--) s = s * 3 + nr[i];
          carry_st = 2'(nr[TRITS]);
          zero_st = zero_of(s);
        end
        res.lo = tryte_pack(s);
      end
      CMD_AND, CMD_OR, CMD_XOR, CMD_CMP: begin
        for (int i = 0; i < TRITS; i++)
          case (cmd)
            CMD_AND: tr[i] = (ta[i] < tb[i]) ? ta[i] : tb[i];
            CMD_OR:  tr[i] = (ta[i] > tb[i]) ? ta[i] : tb[i];
            CMD_XOR: tr[i] = 1 - (ta[i] - 1) * (tb[i] - 1);
            default: tr[i] = 2 - ta[i];
          endcase
        s = 0;
        for (int i = TRITS - 1; i >= 0; i--) s = s * 3 + tr[i];
        res.lo = tryte_pack(s);
        zero_st = zero_of(s);
      end
      default: ;
    endcase
    res.zero = zero_st;
    res.carry = carry_st;
    return res;
  endfunction

  assign pending = alu_results_q.size();

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      carry_st = 2'd0;
      zero_st = 2'd0;
      alu_results_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        alu_results_q.push_back(alu_compute(in_command, in_operand_a, in_operand_b));
      if (out_valid && !out_stall) begin
        if (alu_results_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = alu_results_q.pop_front();
          if (out_result_low !== want.lo || out_result_high !== want.hi ||
              out_zero_trit !== want.zero || out_carry_trit !== want.carry ||
              out_divide_by_zero !== want.dbz) begin
            fail_count <= fail_count + 1;
            if (out_result_low !== want.lo)
              $error("result_low expected %h got %h", want.lo, out_result_low);
            if (out_result_high !== want.hi)
              $error("result_high expected %h got %h", want.hi, out_result_high);
            if (out_zero_trit !== want.zero)
              $error("zero_trit expected %0d got %0d", want.zero, out_zero_trit);
            if (out_carry_trit !== want.carry)
              $error("carry_trit expected %0d got %0d", want.carry, out_carry_trit);
            if (out_divide_by_zero !== want.dbz)
              $error("divide_by_zero expected %0d got %0d", want.dbz,
                     out_divide_by_zero);
          end
        end
      end
    end
  end
endmodule

// ----- test/ternary_tryte_alu_core_tb.sv -----
module ternary_tryte_alu_core_tb import tta_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 930;
  localparam int WATCHDOG_LIMIT = 20000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [CW-1:0] in_command = '0;
  logic [FW-1:0] in_operand_a = '0;
  logic [FW-1:0] in_operand_b = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [FW-1:0] out_result_low, out_result_high;
  logic [1:0]    out_zero_trit, out_carry_trit;
  logic          out_divide_by_zero;
  int            fail_count, pending;
  int            idle_cycles = 0;
  bit            sending_done = 1'b0;
  bit            steady_phase = 1'b0;

  always #5 clk = ~clk;

  ternary_tryte_alu_core DUT (.*);
  ternary_tryte_alu_core_chk u_chk (.*);

  // receiver: random stall, one long hold-off, a quiet stretch
  initial begin
    int n;
    n = 0;
    repeat (12) @(posedge clk);
    forever begin
      @(posedge clk);
      n++;
      if (n >= 150 && n < 450) out_stall <= 1'b1;
      else if (steady_phase) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL ternary_tryte_alu_core");
      $finish;
    end
  end

  function automatic logic [FW-1:0] rand_tryte();
    logic [FW-1:0] p;
    case ($urandom_range(9))
      0: p = '0;
      1: p = {TRITS{2'd2}};
      2: p = {TRITS{2'd3}};
      3: p = FW'($urandom_range(8));
      default: p = FW'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_beat(logic [3:0] cmd, logic [FW-1:0] a, logic [FW-1:0] b);
    while (!steady_phase && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [3:0] cmd;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, every command, code 3, divide by zero, unused codes
    send_beat(CMD_ADD, {TRITS{2'd2}}, 12'h001);
    send_beat(CMD_ADD, 12'h000, 12'h000);
    send_beat(CMD_SUB, 12'h000, 12'h001);
    send_beat(CMD_SUB, 12'hFFF, 12'hAAA);
    send_beat(CMD_MUL, 12'hFFF, 12'hFFF);
    send_beat(CMD_MUL, 12'h000, 12'h5A5);
    send_beat(CMD_DIV, 12'h9A6, 12'h000);
    send_beat(CMD_DIV, 12'h000, 12'h000);
    send_beat(CMD_DIV, 12'hAAA, 12'h002);
    send_beat(CMD_ROTL, 12'h006, 12'h001);
    send_beat(CMD_ROTR, 12'h906, 12'h012);
    send_beat(CMD_ADD, {TRITS{2'd2}}, 12'h002);
    send_beat(CMD_ROTLC, 12'h802, 12'h001);
    send_beat(CMD_ROTRC, 12'h123, 12'h003);
    send_beat(CMD_ROTLC, 12'h456, 12'h000);
    send_beat(CMD_ROTRC, 12'h456, 12'h021);
    send_beat(CMD_AND, 12'hFFF, 12'h9B4);
    send_beat(CMD_OR, 12'h000, 12'hE1D);
    send_beat(CMD_XOR, 12'h6C9, 12'h9C6);
    send_beat(CMD_CMP, 12'hFFF, 12'h000);
    send_beat(CMD_CMP, 12'hAAA, 12'hFFF);
    send_beat(4'd12, 12'h123, 12'h321);
    send_beat(4'd15, 12'hFFF, 12'hFFF);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_phase <= (i >= 400 && i < 520);
      cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      send_beat(cmd, rand_tryte(), rand_tryte());
    end
    in_valid <= 1'b0;
    sending_done <= 1'b1;
  end

  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS ternary_tryte_alu_core");
    else $display("FAIL ternary_tryte_alu_core");
    $finish;
  end
endmodule
